@@ design/fmdrf_pkg.sv @@
// types, field widths and codes shared by the duplicate filter files
package fmdrf_pkg;

  localparam int ADDR_W    = 48;
  localparam int SEQ_W     = 8;
  localparam int TIME_W    = 32;
  localparam int HOP_W     = 8;
  localparam int LEN_W     = 8;
  localparam int SIG_W     = 8;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 2;
  localparam int VERDICT_W = 2;
  localparam int SLOT_W    = 4;
  localparam int STATUS_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPIRY_MS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HOPS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH  = 2'd3;

  // register reset values
  localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST = '0;
  localparam logic [TIME_W-1:0] EXPIRY_MS_RST   = 32'd5000;
  localparam logic [HOP_W-1:0]  MAX_HOPS_RST    = 8'd3;
  localparam logic [LEN_W-1:0]  MIN_LENGTH_RST  = 8'd10;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_SHORT  = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_OWN    = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_DUP    = 2'd3;

  // peer table status codes
  localparam logic [STATUS_W-1:0] PEER_UPDATED  = 2'd0;
  localparam logic [STATUS_W-1:0] PEER_APPENDED = 2'd1;
  localparam logic [STATUS_W-1:0] PEER_FULL     = 2'd2;

  // longest packet that is still rebroadcast
  localparam logic [LEN_W-1:0] RELAY_MAX_LENGTH = 8'd250;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] stamp;
  } ring_entry_t;

  typedef struct packed {
    logic              ring_mode;   // 1: full ring test, 0: address only
    logic              entry_valid;
    logic [ADDR_W-1:0] key_addr;
    logic [SEQ_W-1:0]  key_seq;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] expiry;
  } cmp_req_t;

endpackage

@@ design/fmdrf_ifs.sv @@
// valid/ready channels for packet headers and filter results
interface fmdrf_in_if;
  logic                              valid;
  logic                              ready;
  logic [fmdrf_pkg::LEN_W-1:0]       packet_length;
  logic [fmdrf_pkg::ADDR_W-1:0]      source_address;
  logic [fmdrf_pkg::SEQ_W-1:0]       sequence_req;
  logic [fmdrf_pkg::HOP_W-1:0]       hops;
  logic signed [fmdrf_pkg::SIG_W-1:0] signal_dbm;
  logic [fmdrf_pkg::TIME_W-1:0]      now_ms;

  modport source (output valid, packet_length, source_address, sequence_req, hops,
                  signal_dbm, now_ms, input ready);
  modport sink (input valid, packet_length, source_address, sequence_req, hops,
                signal_dbm, now_ms, output ready);
endinterface

interface fmdrf_out_if;
  logic                               valid;
  logic                               ready;
  logic [fmdrf_pkg::VERDICT_W-1:0]    verdict;
  logic                               deliver;
  logic                               relay;
  logic [fmdrf_pkg::HOP_W-1:0]        relay_hops;
  logic signed [fmdrf_pkg::SIG_W-1:0] last_signal;
  logic [fmdrf_pkg::SLOT_W-1:0]       peer_slot;
  logic [fmdrf_pkg::STATUS_W-1:0]     peer_status;

  modport source (output valid, verdict, deliver, relay, relay_hops, last_signal, peer_slot,
                  peer_status, input ready);
  modport sink (input valid, verdict, deliver, relay, relay_hops, last_signal, peer_slot,
                peer_status, output ready);
endinterface

@@ design/fmdrf_cmp_unit.sv @@
// shared entry compare: address match, plus sequence and age window for ring entries
module fmdrf_cmp_unit (
  input  fmdrf_pkg::cmp_req_t    req,
  input  fmdrf_pkg::ring_entry_t entry,
  output logic                   hit
);

  logic [fmdrf_pkg::TIME_W-1:0] age;
  logic                         addr_eq;
  logic                         fresh;

  // age wraps modulo 2^32
  assign age     = req.now - entry.stamp;
  assign addr_eq = (entry.addr == req.key_addr);
  assign fresh   = req.entry_valid && (entry.seq == req.key_seq) && (age <= req.expiry);
  assign hit     = addr_eq && (!req.ring_mode || fresh);

endmodule

@@ design/flood_mesh_dedup_relay_filter_core.sv @@
// top level of the flooding duplicate-suppression filter
//
// in_ch carries one received packet header per transfer; out_ch returns exactly
// one result per header (verdict, deliver/relay flags, relay hop count, last
// accepted signal strength and peer table outcome). cfg_we/cfg_index/cfg_data
// write the four registers; only write while no header is in flight.
// in_ch.ready is high only while the sequencer is idle, one header at a time.
// a header first gets the length and own-address tests in ST_CHECK (a header
// dropped there goes straight to ST_FINISH), then the duplicate ring is scanned
// entry by entry, ST_RREAD then ST_RCMP, through a single registered memory
// read port and the shared compare unit, then the peer table is scanned the
// same way up to the fill count; a duplicate hit ends the scan early.
// results sit in an output register, so the next header is taken while a
// result still waits; a stalled out_ch holds the sequencer in its last step
// until the register frees up.
// reset clears the ring valid bits, write pointer, peer fill count, last signal
// and registers to their defaults; no clearing pass is needed.
module flood_mesh_dedup_relay_filter_core #(
  parameter int RING_DEPTH = 32,
  parameter int PEER_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  fmdrf_in_if.sink                           in_ch,
  fmdrf_out_if.source                        out_ch,
  input  logic                               cfg_we,
  input  logic [fmdrf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fmdrf_pkg::CFG_W-1:0]        cfg_data
);

  localparam int RW   = $clog2(RING_DEPTH);
  localparam int RCW  = $clog2(RING_DEPTH + 1);
  localparam int PW   = (PEER_DEPTH > 1) ? $clog2(PEER_DEPTH) : 1;
  localparam int CNTW = $clog2(PEER_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_RREAD  = 3'd2;
  localparam logic [2:0] ST_RCMP   = 3'd3;
  localparam logic [2:0] ST_PREAD  = 3'd4;
  localparam logic [2:0] ST_PCMP   = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  // configuration registers
  logic [fmdrf_pkg::ADDR_W-1:0] own_address_r;
  logic [fmdrf_pkg::TIME_W-1:0] expiry_ms_r;
  logic [fmdrf_pkg::HOP_W-1:0]  max_hops_r;
  logic [fmdrf_pkg::LEN_W-1:0]  min_length_r;

  // header under work
  logic [fmdrf_pkg::LEN_W-1:0]  len_r;
  logic [fmdrf_pkg::ADDR_W-1:0] src_r;
  logic [fmdrf_pkg::SEQ_W-1:0]  seq_r;
  logic [fmdrf_pkg::HOP_W-1:0]  hops_r;
  logic [fmdrf_pkg::SIG_W-1:0]  sig_r;
  logic [fmdrf_pkg::TIME_W-1:0] now_r;

  logic [2:0] state_r;

  // duplicate ring
  fmdrf_pkg::ring_entry_t ring_mem [RING_DEPTH];
  fmdrf_pkg::ring_entry_t ring_rd_r;
  logic [RING_DEPTH-1:0]  ring_valid_r;
  logic                   ring_vrd_r;
  logic [RW-1:0]          ring_wp_r;
  logic [RW-1:0]          ring_wp_nxt;
  logic [RCW-1:0]         ridx_r;
  logic                   ring_we;

  // peer table
  logic [fmdrf_pkg::ADDR_W-1:0] peer_mem [PEER_DEPTH];
  logic [fmdrf_pkg::ADDR_W-1:0] peer_rd_r;
  logic [CNTW-1:0]              peer_count_r;
  logic [CNTW-1:0]              pidx_r;
  logic                         peer_we;

  logic [fmdrf_pkg::SIG_W-1:0] last_sig_r;

  // per-item outcome
  logic [fmdrf_pkg::VERDICT_W-1:0] verdict_r;
  logic [fmdrf_pkg::SLOT_W-1:0]    slot_r;
  logic [fmdrf_pkg::STATUS_W-1:0]  status_r;

  // result register
  logic                            out_valid_r;
  logic [fmdrf_pkg::VERDICT_W-1:0] out_verdict_r;
  logic                            out_deliver_r;
  logic                            out_relay_r;
  logic [fmdrf_pkg::HOP_W-1:0]     out_hops_r;
  logic [fmdrf_pkg::SIG_W-1:0]     out_sig_r;
  logic [fmdrf_pkg::SLOT_W-1:0]    out_slot_r;
  logic [fmdrf_pkg::STATUS_W-1:0]  out_status_r;

  // shared compare unit
  fmdrf_pkg::cmp_req_t    cmp_req;
  fmdrf_pkg::ring_entry_t cmp_entry;
  logic                   cmp_hit;

  logic in_xfer;
  logic out_free;
  logic ring_done;
  logic peer_done;
  logic is_accept;
  logic relay_ok;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign ring_done   = (ridx_r == RCW'(RING_DEPTH));
  assign peer_done   = (pidx_r == peer_count_r);
  assign ring_we     = (state_r == ST_RREAD) && ring_done;
  assign peer_we     = (state_r == ST_PREAD) && peer_done && (peer_count_r < CNTW'(PEER_DEPTH));
  assign ring_wp_nxt = (ring_wp_r == RW'(RING_DEPTH - 1)) ? '0 : ring_wp_r + 1'b1;

  // ring entries: full test; peer entries: address only
  always_comb begin
    cmp_req.ring_mode   = (state_r == ST_RCMP);
    cmp_req.entry_valid = ring_vrd_r;
    cmp_req.key_addr    = src_r;
    cmp_req.key_seq     = seq_r;
    cmp_req.now         = now_r;
    cmp_req.expiry      = expiry_ms_r;
    if (state_r == ST_RCMP) begin
      cmp_entry = ring_rd_r;
    end else begin
      cmp_entry       = '0;
      cmp_entry.addr  = peer_rd_r;
    end
  end

  fmdrf_cmp_unit u_cmp (
    .req   (cmp_req),
    .entry (cmp_entry),
    .hit   (cmp_hit)
  );

  assign is_accept = (verdict_r == fmdrf_pkg::VERDICT_ACCEPT);
  assign relay_ok  = is_accept && (len_r <= fmdrf_pkg::RELAY_MAX_LENGTH) &&
                     (hops_r < max_hops_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= fmdrf_pkg::OWN_ADDRESS_RST;
      expiry_ms_r   <= fmdrf_pkg::EXPIRY_MS_RST;
      max_hops_r    <= fmdrf_pkg::MAX_HOPS_RST;
      min_length_r  <= fmdrf_pkg::MIN_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fmdrf_pkg::REG_OWN_ADDRESS: own_address_r <= cfg_data;
        fmdrf_pkg::REG_EXPIRY_MS:   expiry_ms_r   <= cfg_data[fmdrf_pkg::TIME_W-1:0];
        fmdrf_pkg::REG_MAX_HOPS:    max_hops_r    <= cfg_data[fmdrf_pkg::HOP_W-1:0];
        fmdrf_pkg::REG_MIN_LENGTH:  min_length_r  <= cfg_data[fmdrf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // header capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      len_r  <= in_ch.packet_length;
      src_r  <= in_ch.source_address;
      seq_r  <= in_ch.sequence_req;
      hops_r <= in_ch.hops;
      sig_r  <= in_ch.signal_dbm;
      now_r  <= in_ch.now_ms;
    end
  end

  // ring memory, one registered read port
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_wp_r] <= '{addr: src_r, seq: seq_r, stamp: now_r};
    end
    ring_rd_r  <= ring_mem[ridx_r[RW-1:0]];
    ring_vrd_r <= ring_valid_r[ridx_r[RW-1:0]];
  end

  // peer memory, one registered read port
  always_ff @(posedge clk) begin
    if (peer_we) begin
      peer_mem[peer_count_r[PW-1:0]] <= src_r;
    end
    peer_rd_r <= peer_mem[pidx_r[PW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ring_valid_r <= '0;
      ring_wp_r    <= '0;
      peer_count_r <= '0;
      last_sig_r   <= '0;
      ridx_r       <= '0;
      pidx_r       <= '0;
      verdict_r    <= fmdrf_pkg::VERDICT_ACCEPT;
      slot_r       <= '0;
      status_r     <= fmdrf_pkg::PEER_UPDATED;
      out_valid_r  <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          slot_r   <= '0;
          status_r <= fmdrf_pkg::PEER_UPDATED;
          ridx_r   <= '0;
          pidx_r   <= '0;
          // length test first, then own address, then the ring
          if (len_r < min_length_r) begin
            verdict_r <= fmdrf_pkg::VERDICT_SHORT;
            state_r   <= ST_FINISH;
          end else if (src_r == own_address_r) begin
            verdict_r <= fmdrf_pkg::VERDICT_OWN;
            state_r   <= ST_FINISH;
          end else begin
            verdict_r <= fmdrf_pkg::VERDICT_ACCEPT;
            state_r   <= ST_RREAD;
          end
        end
        ST_RREAD: begin
          if (ring_done) begin
            // no fresh duplicate: record it and move to the peer table
            ring_valid_r[ring_wp_r] <= 1'b1;
            ring_wp_r               <= ring_wp_nxt;
            last_sig_r              <= sig_r;
            state_r                 <= ST_PREAD;
          end else begin
            state_r <= ST_RCMP;
          end
        end
        ST_RCMP: begin
          if (cmp_hit) begin
            verdict_r <= fmdrf_pkg::VERDICT_DUP;
            state_r   <= ST_FINISH;
          end else begin
            ridx_r  <= ridx_r + 1'b1;
            state_r <= ST_RREAD;
          end
        end
        ST_PREAD: begin
          if (peer_done) begin
            if (peer_count_r < CNTW'(PEER_DEPTH)) begin
              slot_r       <= fmdrf_pkg::SLOT_W'(peer_count_r);
              status_r     <= fmdrf_pkg::PEER_APPENDED;
              peer_count_r <= peer_count_r + 1'b1;
            end else begin
              slot_r   <= '0;
              status_r <= fmdrf_pkg::PEER_FULL;
            end
            state_r <= ST_FINISH;
          end else begin
            state_r <= ST_PCMP;
          end
        end
        ST_PCMP: begin
          if (cmp_hit) begin
            slot_r   <= fmdrf_pkg::SLOT_W'(pidx_r);
            status_r <= fmdrf_pkg::PEER_UPDATED;
            state_r  <= ST_FINISH;
          end else begin
            pidx_r  <= pidx_r + 1'b1;
            state_r <= ST_PREAD;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      // result register: load on the last step, clear once taken
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with the transfer into the output register
  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && out_free) begin
      out_verdict_r <= verdict_r;
      out_deliver_r <= is_accept;
      out_relay_r   <= relay_ok;
      out_hops_r    <= relay_ok ? hops_r + 1'b1 : '0;
      out_sig_r     <= last_sig_r;
      out_slot_r    <= slot_r;
      out_status_r  <= status_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.verdict     = out_verdict_r;
  assign out_ch.deliver     = out_deliver_r;
  assign out_ch.relay       = out_relay_r;
  assign out_ch.relay_hops  = out_hops_r;
  assign out_ch.last_signal = out_sig_r;
  assign out_ch.peer_slot   = out_slot_r;
  assign out_ch.peer_status = out_status_r;

  // a taken header always starts the sequencer
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_CHECK)
    else $error("header transfer did not start the sequencer");

  // dropped packets never deliver, relay or touch the peer table
  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_verdict_r != fmdrf_pkg::VERDICT_ACCEPT |->
      !out_deliver_r && !out_relay_r && out_status_r == fmdrf_pkg::PEER_UPDATED &&
      out_slot_r == '0)
    else $error("dropped packet shows accept side effects");

  // the peer table never fills past its depth
  a_peer_bound: assert property (@(posedge clk) disable iff (!rst_n)
    peer_count_r <= CNTW'(PEER_DEPTH))
    else $error("peer fill count past table depth");

  // each ring write moves the round-robin pointer
  a_ring_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ring_we |=> ring_wp_r != $past(ring_wp_r))
    else $error("ring write pointer did not advance");

  // a relay is only flagged for a delivered packet with a nonzero hop count
  a_relay_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_relay_r |-> out_deliver_r && out_hops_r != '0)
    else $error("relay flagged without delivery");

endmodule

@@ sim/flood_mesh_dedup_relay_filter_core_tb.sv @@
// self-checking testbench for the flooding duplicate-suppression filter core
module flood_mesh_dedup_relay_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fmdrf_pkg::*;

  localparam int RING_N     = 32;
  localparam int PEER_N     = 16;
  localparam int POOL_N     = 32;
  // no transfer on any channel for this many cycles means the block hung
  localparam int IDLE_LIMIT = 5000;
  // long enough for a header to scan the ring and the peer table
  localparam int DRAIN_WAIT = 110;
  localparam int SETTLE     = 8;
  // cycles the result side holds off once, so that the input backs up
  localparam int HOLD_OFF   = 400;
  localparam int HOLD_AT    = 120;

  typedef struct {
    logic [LEN_W-1:0]        pkt_len;
    logic [ADDR_W-1:0]       src;
    logic [SEQ_W-1:0]        seq;
    logic [HOP_W-1:0]        hops;
    logic signed [SIG_W-1:0] sig;
    logic [TIME_W-1:0]       now;
  } header_t;

  typedef struct {
    logic [VERDICT_W-1:0]    verdict;
    logic                    deliver;
    logic                    relay;
    logic [HOP_W-1:0]        relay_hops;
    logic signed [SIG_W-1:0] last_signal;
    logic [SLOT_W-1:0]       peer_slot;
    logic [STATUS_W-1:0]     peer_status;
  } filter_result_t;

  // filter state mirror: works out each verdict when the header transfer happens,
  // and holds the verdicts in order until the block hands them back
  class dedup_scoreboard;
    logic [ADDR_W-1:0]       own_addr;
    logic [TIME_W-1:0]       expiry;
    logic [HOP_W-1:0]        hop_limit;
    logic [LEN_W-1:0]        len_floor;
    bit                      ring_live [RING_N];
    logic [ADDR_W-1:0]       ring_addr [RING_N];
    logic [SEQ_W-1:0]        ring_seq  [RING_N];
    logic [TIME_W-1:0]       ring_time [RING_N];
    int unsigned             ring_next;
    logic [ADDR_W-1:0]       peer_key  [PEER_N];
    int unsigned             peer_fill;
    logic signed [SIG_W-1:0] held_signal;
    filter_result_t          verdicts_due [$];
    int                      errors;
    int                      verdict_seen [4];
    int                      peer_seen [3];
    int                      relayed;

    function new();
      own_addr    = OWN_ADDRESS_RST;
      expiry      = EXPIRY_MS_RST;
      hop_limit   = MAX_HOPS_RST;
      len_floor   = MIN_LENGTH_RST;
      foreach (ring_live[i]) ring_live[i] = 1'b0;
      ring_next   = 0;
      peer_fill   = 0;
      held_signal = '0;
      errors      = 0;
      relayed     = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_OWN_ADDRESS: own_addr  = data[ADDR_W-1:0];
        REG_EXPIRY_MS:   expiry    = data[TIME_W-1:0];
        REG_MAX_HOPS:    hop_limit = data[HOP_W-1:0];
        REG_MIN_LENGTH:  len_floor = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    function void note_header(header_t h);
      filter_result_t   r;
      logic [TIME_W-1:0] age;
      bit               hit;
      bit               found;
      r = '{default: '0};
      hit = 1'b0;
      found = 1'b0;
      // short beats own address, own address beats duplicate
      if (h.pkt_len < len_floor) begin
        r.verdict = VERDICT_SHORT;
      end else if (h.src == own_addr) begin
        r.verdict = VERDICT_OWN;
      end else begin
        for (int i = 0; i < RING_N; i++) begin
          age = h.now - ring_time[i];  // wraps modulo 2^32
          if (ring_live[i] && age <= expiry && ring_addr[i] == h.src && ring_seq[i] == h.seq)
            hit = 1'b1;
        end
        r.verdict = hit ? VERDICT_DUP : VERDICT_ACCEPT;
      end
      if (r.verdict == VERDICT_ACCEPT) begin
        ring_live[ring_next] = 1'b1;
        ring_addr[ring_next] = h.src;
        ring_seq[ring_next]  = h.seq;
        ring_time[ring_next] = h.now;
        ring_next = (ring_next + 1) % RING_N;
        held_signal = h.sig;
        for (int i = 0; i < PEER_N; i++) begin
          if (!found && i < peer_fill && peer_key[i] == h.src) begin
            r.peer_slot   = SLOT_W'(i);
            r.peer_status = PEER_UPDATED;
            found = 1'b1;
          end
        end
        // the table only grows; once full, unknown peers are not stored
        if (!found && peer_fill < PEER_N) begin
          peer_key[peer_fill] = h.src;
          r.peer_slot   = SLOT_W'(peer_fill);
          r.peer_status = PEER_APPENDED;
          peer_fill++;
        end else if (!found) begin
          r.peer_slot   = '0;
          r.peer_status = PEER_FULL;
        end
        r.deliver = 1'b1;
        if (h.pkt_len <= RELAY_MAX_LENGTH && h.hops < hop_limit) begin
          r.relay      = 1'b1;
          r.relay_hops = h.hops + 8'd1;
        end
      end
      r.last_signal = held_signal;
      verdicts_due.push_back(r);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(filter_result_t got);
      filter_result_t want;
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: result with no header waiting, verdict %0d", $time, got.verdict);
        return;
      end
      want = verdicts_due.pop_front();
      verdict_seen[want.verdict]++;
      relayed += want.relay;
      if (want.verdict == VERDICT_ACCEPT) peer_seen[want.peer_status]++;
      compare_field("verdict", want.verdict, got.verdict);
      compare_field("deliver", want.deliver, got.deliver);
      compare_field("relay", want.relay, got.relay);
      compare_field("relay_hops", want.relay_hops, got.relay_hops);
      compare_field("last_signal", $unsigned(want.last_signal), $unsigned(got.last_signal));
      compare_field("peer_slot", want.peer_slot, got.peer_slot);
      compare_field("peer_status", want.peer_status, got.peer_status);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  fmdrf_in_if  in_if ();
  fmdrf_out_if out_if ();

  flood_mesh_dedup_relay_filter_core #(
    .RING_DEPTH(RING_N),
    .PEER_DEPTH(PEER_N)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  dedup_scoreboard   board = new();
  logic [ADDR_W-1:0] addr_pool [POOL_N];
  logic [TIME_W-1:0] clock_ms;       // running packet time, jumps now and then
  int                headers_sent;
  int                settings_used;
  bit                in_burst;       // sender offers back to back while set
  bit                out_burst;      // receiver takes back to back while set
  int                idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap before a transfer: mostly none or short, a few long ones
  function automatic int pick_gap(bit burst);
    int pick;
    pick = $urandom_range(0, 99);
    if (burst || pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // random header: sources mostly from a small pool and sequence numbers from a
  // narrow range, so repeats inside and outside the expiry window are common
  function automatic header_t make_header(int pool_n);
    header_t h;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 78)      h.src = addr_pool[$urandom_range(0, pool_n - 1)];
    else if (pick < 88) h.src = board.own_addr;
    else                h.src = ADDR_W'({$urandom, $urandom});
    // length right at the threshold, near the relay limit, or anywhere
    pick = $urandom_range(0, 99);
    if (pick < 10)      h.pkt_len = board.len_floor;
    else if (pick < 20) h.pkt_len = board.len_floor - 8'd1;
    else if (pick < 35) h.pkt_len = LEN_W'($urandom_range(240, 255));
    else                h.pkt_len = LEN_W'($urandom);
    if ($urandom_range(0, 99) < 80) h.seq = SEQ_W'($urandom_range(0, 3));
    else                            h.seq = SEQ_W'($urandom);
    if ($urandom_range(0, 99) < 70) h.hops = HOP_W'($urandom_range(0, 6));
    else                            h.hops = HOP_W'($urandom);
    h.sig = SIG_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick >= 96)      clock_ms = $urandom;
    else if (pick >= 12) clock_ms = clock_ms + TIME_W'($urandom_range(1, 400));
    h.now = clock_ms;
    return h;
  endfunction

  // offer one header and hold it until the transfer; valid stays high after it
  // so back-to-back headers never drop valid within a step
  task automatic send_header(header_t h);
    int gap;
    if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
    gap = pick_gap(in_burst);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.packet_length  <= h.pkt_len;
    in_if.source_address <= h.src;
    in_if.sequence_req   <= h.seq;
    in_if.hops           <= h.hops;
    in_if.signal_dbm     <= h.sig;
    in_if.now_ms         <= h.now;
    do @(posedge clk); while (!in_if.ready);
    board.note_header(h);
    headers_sent++;
  endtask

  task automatic send_fields(logic [LEN_W-1:0] len, logic [ADDR_W-1:0] src,
                             logic [SEQ_W-1:0] seq, logic [HOP_W-1:0] hops,
                             logic signed [SIG_W-1:0] sig, logic [TIME_W-1:0] now);
    header_t h;
    h = '{pkt_len: len, src: src, seq: seq, hops: hops, sig: sig, now: now};
    send_header(h);
  endtask

  // registers only change with nothing in flight: drain, settle, then write all four
  task automatic reconfigure(logic [ADDR_W-1:0] own, logic [TIME_W-1:0] exp_ms,
                             logic [HOP_W-1:0] hop_max, logic [LEN_W-1:0] min_len);
    logic [CFG_W-1:0] vals [4];
    in_if.valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    vals[REG_OWN_ADDRESS] = CFG_W'(own);
    vals[REG_EXPIRY_MS]   = CFG_W'(exp_ms);
    vals[REG_MAX_HOPS]    = CFG_W'(hop_max);
    vals[REG_MIN_LENGTH]  = CFG_W'(min_len);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      board.write_register(CFG_IDX_W'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(logic [ADDR_W-1:0] own, logic [TIME_W-1:0] exp_ms,
                           logic [HOP_W-1:0] hop_max, logic [LEN_W-1:0] min_len,
                           int items, int pool_n);
    reconfigure(own, exp_ms, hop_max, min_len);
    repeat (items) send_header(make_header(pool_n));
  endtask

  // result side: random ready gaps, one long hold-off to back the block up
  initial begin
    filter_result_t got;
    int             gap;
    int             taken;
    bit             held;
    taken = 0;
    held  = 1'b0;
    out_burst = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      if (!held && taken >= HOLD_AT) begin
        gap  = HOLD_OFF;
        held = 1'b1;
      end else begin
        gap = pick_gap(out_burst);
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got.verdict     = out_if.verdict;
      got.deliver     = out_if.deliver;
      got.relay       = out_if.relay;
      got.relay_hops  = out_if.relay_hops;
      got.last_signal = out_if.last_signal;
      got.peer_slot   = out_if.peer_slot;
      got.peer_status = out_if.peer_status;
      board.check_result(got);
      taken++;
    end
  end

  // hang detector: restarts on any transfer or register write
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[flood_mesh_dedup_relay_filter_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] addr_ones;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] t1;
    addr_a    = 48'h0123_4567_89AB;
    addr_b    = 48'hFEDC_BA98_7654;
    addr_ones = '1;
    t0        = 32'hFFFF_F000;   // close to the top so the age test wraps
    t1        = 32'h0000_0100;
    idle_cycles   = 0;
    headers_sent  = 0;
    settings_used = 0;
    in_burst      = 1'b0;
    foreach (addr_pool[i]) addr_pool[i] = ADDR_W'({$urandom, $urandom});
    clock_ms = $urandom;

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    in_if.valid          <= 1'b0;
    in_if.packet_length  <= '0;
    in_if.source_address <= '0;
    in_if.sequence_req   <= '0;
    in_if.hops           <= '0;
    in_if.signal_dbm     <= '0;
    in_if.now_ms         <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset register values (own address 0)
    send_fields(8'd0,   48'd0,     8'd0,   8'd0,   -8'sd1,   t0);        // short and own: short wins
    send_fields(8'd9,   addr_a,    8'd1,   8'd0,   -8'sd5,   t0);        // one below the floor
    send_fields(8'd10,  48'd0,     8'd0,   8'd0,   8'sd3,    t0);        // own address
    send_fields(8'd10,  addr_a,    8'd1,   8'd0,   -8'sd128, t0);        // accept, new peer
    send_fields(8'd100, addr_a,    8'd1,   8'd0,   8'sd7,    t0 + 5000); // age equals expiry
    send_fields(8'd100, addr_a,    8'd1,   8'd1,   8'sd8,    t0 + 5001); // just expired
    send_fields(8'd255, addr_b,    8'd0,   8'd0,   8'sd127,  t0 + 5002); // too long to relay
    send_fields(8'd250, addr_b,    8'd2,   8'd2,   8'sd1,    t0 + 5003); // longest relayed
    send_fields(8'd11,  addr_b,    8'd3,   8'd3,   8'sd2,    t0 + 5004); // hops at the limit
    send_fields(8'd200, addr_b,    8'd4,   8'd255, 8'sd3,    t0 + 5005);
    send_fields(8'd200, addr_ones, 8'd255, 8'd0,   -8'sd1,   t0 + 6000);
    send_fields(8'd5,   addr_ones, 8'd255, 8'd0,   8'sd9,    t0 + 6000); // drop keeps last signal
    send_fields(8'd200, addr_ones, 8'd255, 8'd0,   8'sd9,    t0 + 6000); // duplicate

    // zero expiry: only a header with the very same time still matches
    reconfigure(addr_ones, 32'd0, 8'd255, 8'd0);
    send_fields(8'd0,   addr_ones, 8'd1,   8'd0,   8'sd4,    t1);        // own, length 0 passes
    send_fields(8'd0,   addr_a,    8'd9,   8'd254, 8'sd4,    t1);        // relay with 255 hops
    send_fields(8'd0,   addr_a,    8'd9,   8'd254, 8'sd5,    t1);        // same time: duplicate
    send_fields(8'd0,   addr_a,    8'd9,   8'd254, 8'sd6,    t1 + 1);    // one ms later: new
    send_fields(8'd255, addr_a,    8'd9,   8'd0,   8'sd7,    t1 + 1);

    // widest expiry: every live ring entry is inside the age window; nothing relays
    reconfigure(addr_a, 32'hFFFF_FFFF, 8'd0, 8'd255);
    send_fields(8'd254, addr_b,    8'd0,   8'd0,   8'sd1,    t1 + 2);    // short
    send_fields(8'd255, addr_a,    8'd0,   8'd0,   8'sd1,    t1 + 2);    // own
    send_fields(8'd255, addr_b,    8'd2,   8'd0,   8'sd1,    t1);        // old entry still live
    send_fields(8'd255, addr_b,    8'd77,  8'd0,   -8'sd60,  t1 + 3);    // accept, no relay

    // random phases; later ones widen the source pool so the peer table fills
    run_phase(addr_pool[0], 32'd5000, 8'd3, 8'd10, 250, 8);
    run_phase(addr_ones, 32'hFFFF_FFFF, 8'd255, 8'd0, 100, 12);
    run_phase(ADDR_W'({$urandom, $urandom}), 32'd0, 8'd0, 8'd255, 60, 12);
    run_phase(addr_pool[3], 32'd300, 8'd5, 8'd20, 250, POOL_N);
    run_phase(OWN_ADDRESS_RST, EXPIRY_MS_RST, MAX_HOPS_RST, MIN_LENGTH_RST, 140, POOL_N);

    in_if.valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d headers under %0d register settings: %0d accepted, %0d short, %0d own, %0d dup",
             headers_sent, settings_used, board.verdict_seen[VERDICT_ACCEPT],
             board.verdict_seen[VERDICT_SHORT], board.verdict_seen[VERDICT_OWN],
             board.verdict_seen[VERDICT_DUP]);
    $display("%0d relayed; peer table: %0d updated, %0d appended, %0d not stored (full)",
             board.relayed, board.peer_seen[PEER_UPDATED], board.peer_seen[PEER_APPENDED],
             board.peer_seen[PEER_FULL]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[flood_mesh_dedup_relay_filter_core] OK");
    end else begin
      $display("[flood_mesh_dedup_relay_filter_core] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/fmdrf_pkg.sv
design/fmdrf_ifs.sv
design/fmdrf_cmp_unit.sv
design/flood_mesh_dedup_relay_filter_core.sv
sim/flood_mesh_dedup_relay_filter_core_tb.sv
